### sv/gms_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and pixel arithmetic for the gradient magnitude stream.
package gms_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 4096;
  localparam int MaxRes    = 3;

  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int PixW      = 24;
  localparam int MagW      = 8;
  localparam int OutRowW   = 12;
  localparam int OutColW   = 10;

  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 13;
  localparam int WidthCfgW = 11;
  localparam int HeightCfgW = 13;

  localparam logic [CfgIdxW-1:0] RegColorMode   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 2'd2;

  localparam int ResetWidth   = 640;
  localparam int ResetHeight  = 480;
  localparam int ResetLastCol = ((ResetWidth > MaxWidth) ? MaxWidth : ResetWidth) - 1;
  localparam int ResetLastRow = ((ResetHeight > MaxHeight) ? MaxHeight : ResetHeight) - 1;

  localparam int GrayAccW  = 22;
  localparam int GrayShift = 14;
  localparam logic [GrayAccW-1:0] GrayCoefB = 22'd1868;
  localparam logic [GrayAccW-1:0] GrayCoefG = 22'd9617;
  localparam logic [GrayAccW-1:0] GrayCoefR = 22'd4899;
  localparam logic [GrayAccW-1:0] GrayRound = 22'd8192;

  localparam logic [MagW-1:0] MagMax = 8'd255;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  typedef struct packed {
    logic [MagW-1:0]    magnitude;
    logic [OutRowW-1:0] out_row;
    logic [OutColW-1:0] out_col;
    logic               last_in_run;
    logic               frame_done;
  } res_t;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            sel;
    logic            has_up;
    logic            second_row;
    logic            last_row;
    logic            col_first;
    logic            col_second;
    logic            col_last;
  } item_ctl_t;

  typedef struct packed {
    pix_t left;
    pix_t mid;
    pix_t right;
    pix_t older;
    pix_t run1;
    pix_t run2;
  } taps_t;

  typedef struct packed {
    pix_t ka;
    pix_t kb;
    logic dbl;
  } pair_t;

  typedef struct packed {
    logic [MaxRes-1:0] present;
    res_t [MaxRes-1:0] res;
  } bundle_t;

  function automatic pix_t pix_key(pix_t p, logic gray_mode);
    logic [GrayAccW-1:0] acc;
    pix_t k;
    acc = GrayCoefB * GrayAccW'(p.blue) + GrayCoefG * GrayAccW'(p.green)
        + GrayCoefR * GrayAccW'(p.red) + GrayRound;
    if (gray_mode) begin
      k.blue  = acc[GrayShift +: 8];
      k.green = '0;
      k.red   = '0;
    end else begin
      k = p;
    end
    return k;
  endfunction

  function automatic logic [7:0] abs_diff(logic [7:0] a, logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [7:0] key_dist(pix_t a, pix_t b);
    logic [7:0] db;
    logic [7:0] dg;
    logic [7:0] dr;
    logic [7:0] m;
    db = abs_diff(a.blue, b.blue);
    dg = abs_diff(a.green, b.green);
    dr = abs_diff(a.red, b.red);
    m  = (db > dg) ? db : dg;
    return (m > dr) ? m : dr;
  endfunction

  function automatic logic [MagW-1:0] mag_sum(logic [7:0] dx, logic dbl_x,
                                              logic [7:0] dy, logic dbl_y);
    logic [8:0] gx;
    logic [8:0] gy;
    logic [9:0] s;
    gx = dbl_x ? {dx, 1'b0} : {1'b0, dx};
    gy = dbl_y ? {dy, 1'b0} : {1'b0, dy};
    s  = {1'b0, gx} + {1'b0, gy};
    return (s > {2'b00, MagMax}) ? MagMax : s[MagW-1:0];
  endfunction

endpackage

### sv/gms_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
module gms_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/gms_lbuf.sv
`timescale 1ns / 1ps
// Two line stores with their read-ahead window, row head copies and current-row history.
module gms_lbuf (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [gms_pkg::ColW-1:0]     wr_col_i,
  input  logic                         wr_sel_i,
  input  gms_pkg::pix_t                wr_pix_i,
  input  logic                         adv_i,
  input  gms_pkg::item_ctl_t           a_ctl_i,
  input  gms_pkg::pix_t                a_pix_i,
  output gms_pkg::taps_t               taps_o
);

  import gms_pkg::*;

  logic [ColW-1:0] col_next;
  logic            we_older;
  logic            we_newer;
  logic [ColW-1:0] raddr_older;
  logic [ColW-1:0] raddr_newer;
  logic [PixW-1:0] rdata_older;
  logic [PixW-1:0] rdata_newer;
  pix_t            head_q [2];
  pix_t            left_q;
  pix_t            mid_q;
  pix_t            run1_q;
  pix_t            run2_q;
  pix_t            mid_src;
  pix_t            right_src;
  pix_t            older_src;

  // Select 0 writes the current row into the older store and reads the previous row
  // from the newer one; select 1 swaps the roles.
  assign col_next    = wr_col_i + ColW'(1);
  assign we_older    = wr_en_i & ~wr_sel_i;
  assign we_newer    = wr_en_i & wr_sel_i;
  assign raddr_older = wr_sel_i ? col_next : wr_col_i;
  assign raddr_newer = wr_sel_i ? wr_col_i : col_next;

  gms_ram #(
    .Width (PixW),
    .Depth (MaxWidth)
  ) u_older_ram (
    .clk_i   (clk_i),
    .we_i    (we_older),
    .waddr_i (wr_col_i),
    .wdata_i (wr_pix_i),
    .re_i    (wr_en_i),
    .raddr_i (raddr_older),
    .rdata_o (rdata_older)
  );

  gms_ram #(
    .Width (PixW),
    .Depth (MaxWidth)
  ) u_newer_ram (
    .clk_i   (clk_i),
    .we_i    (we_newer),
    .waddr_i (wr_col_i),
    .wdata_i (wr_pix_i),
    .re_i    (wr_en_i),
    .raddr_i (raddr_newer),
    .rdata_o (rdata_newer)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_col_i == '0)) begin
      head_q[wr_sel_i] <= wr_pix_i;
    end
  end

  assign right_src = a_ctl_i.sel ? pix_t'(rdata_older) : pix_t'(rdata_newer);
  assign older_src = a_ctl_i.sel ? pix_t'(rdata_newer) : pix_t'(rdata_older);
  assign mid_src   = a_ctl_i.col_first ? head_q[~a_ctl_i.sel] : mid_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      left_q <= mid_src;
      mid_q  <= right_src;
      run2_q <= run1_q;
      run1_q <= a_pix_i;
    end
  end

  assign taps_o = '{left:  left_q,
                    mid:   mid_src,
                    right: right_src,
                    older: older_src,
                    run1:  run1_q,
                    run2:  run2_q};

endmodule

### sv/gms_grad.sv
`timescale 1ns / 1ps
// Gradient datapath: distance keys and operand pairs, then magnitudes of up to three results.
module gms_grad (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               color_mode_i,
  input  logic               load_i,
  input  logic               take_i,
  input  gms_pkg::item_ctl_t a_ctl_i,
  input  gms_pkg::pix_t      a_pix_i,
  input  gms_pkg::taps_t     taps_i,
  output logic               valid_o,
  output gms_pkg::bundle_t   bundle_o
);

  import gms_pkg::*;

  localparam int PairUpX   = 0;
  localparam int PairUpY   = 1;
  localparam int PairLeftX = 2;
  localparam int PairLeftY = 3;
  localparam int PairEndX  = 4;
  localparam int PairEndY  = 5;

  pix_t k_cur;
  pix_t k_left;
  pix_t k_mid;
  pix_t k_right;
  pix_t k_older;
  pix_t k_run1;
  pix_t k_run2;

  pair_t [2*MaxRes-1:0] pair_d;
  pair_t [2*MaxRes-1:0] pair_q;
  logic  [MaxRes-1:0]   has_d;
  logic  [MaxRes-1:0]   has_q;
  logic  [RowW-1:0]     row_q;
  logic  [ColW-1:0]     col_q;
  logic                 valid_q;
  logic  [MagW-1:0]     mag [MaxRes];

  assign k_cur   = pix_key(a_pix_i, color_mode_i);
  assign k_left  = pix_key(taps_i.left, color_mode_i);
  assign k_mid   = pix_key(taps_i.mid, color_mode_i);
  assign k_right = pix_key(taps_i.right, color_mode_i);
  assign k_older = pix_key(taps_i.older, color_mode_i);
  assign k_run1  = pix_key(taps_i.run1, color_mode_i);
  assign k_run2  = pix_key(taps_i.run2, color_mode_i);

  always_comb begin
    if (a_ctl_i.col_first) begin
      pair_d[PairUpX] = '{ka: k_right, kb: k_mid, dbl: 1'b1};
    end else if (a_ctl_i.col_last) begin
      pair_d[PairUpX] = '{ka: k_mid, kb: k_left, dbl: 1'b1};
    end else begin
      pair_d[PairUpX] = '{ka: k_left, kb: k_right, dbl: 1'b0};
    end
    if (a_ctl_i.second_row) begin
      pair_d[PairUpY] = '{ka: k_cur, kb: k_mid, dbl: 1'b1};
    end else begin
      pair_d[PairUpY] = '{ka: k_older, kb: k_cur, dbl: 1'b0};
    end
    if (a_ctl_i.col_second) begin
      pair_d[PairLeftX] = '{ka: k_cur, kb: k_run1, dbl: 1'b1};
    end else begin
      pair_d[PairLeftX] = '{ka: k_run2, kb: k_cur, dbl: 1'b0};
    end
    pair_d[PairLeftY] = '{ka: k_run1, kb: k_left, dbl: 1'b1};
    pair_d[PairEndX]  = '{ka: k_cur, kb: k_run1, dbl: 1'b1};
    pair_d[PairEndY]  = '{ka: k_cur, kb: k_mid, dbl: 1'b1};
  end

  assign has_d = {a_ctl_i.last_row & a_ctl_i.col_last,
                  a_ctl_i.last_row & ~a_ctl_i.col_first,
                  a_ctl_i.has_up};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pair_q <= pair_d;
      has_q  <= has_d;
      row_q  <= a_ctl_i.row;
      col_q  <= a_ctl_i.col;
    end
  end

  always_comb begin
    for (int i = 0; i < MaxRes; i++) begin
      mag[i] = mag_sum(key_dist(pair_q[2*i].ka, pair_q[2*i].kb), pair_q[2*i].dbl,
                       key_dist(pair_q[2*i+1].ka, pair_q[2*i+1].kb), pair_q[2*i+1].dbl);
    end
  end

  always_comb begin
    bundle_o.present = has_q;
    bundle_o.res[0] = '{magnitude:   mag[0],
                        out_row:     OutRowW'(row_q - RowW'(1)),
                        out_col:     OutColW'(col_q),
                        last_in_run: 1'b0,
                        frame_done:  1'b0};
    bundle_o.res[1] = '{magnitude:   mag[1],
                        out_row:     OutRowW'(row_q),
                        out_col:     OutColW'(col_q - ColW'(1)),
                        last_in_run: 1'b0,
                        frame_done:  1'b0};
    bundle_o.res[2] = '{magnitude:   mag[2],
                        out_row:     OutRowW'(row_q),
                        out_col:     OutColW'(col_q),
                        last_in_run: 1'b0,
                        frame_done:  1'b1};
  end

  assign valid_o = valid_q;

endmodule

### sv/gms_out.sv
`timescale 1ns / 1ps
// Output register that hands out the results of one pixel one transaction at a time.
module gms_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  gms_pkg::bundle_t bundle_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output gms_pkg::res_t    out_data_o
);

  import gms_pkg::*;

  logic [MaxRes-1:0] pend_q;
  res_t [MaxRes-1:0] res_q;
  logic [1:0]        idx;
  logic [MaxRes-1:0] rest;
  logic              fire;

  always_comb begin
    if (pend_q[0]) begin
      idx = 2'd0;
    end else if (pend_q[1]) begin
      idx = 2'd1;
    end else begin
      idx = 2'd2;
    end
    rest                   = pend_q & ~(MaxRes'(1) << idx);
    out_valid_o            = |pend_q;
    fire                   = out_valid_o & ~out_stall_i;
    ready_o                = ~out_valid_o | (fire & (rest == '0));
    out_data_o             = res_q[idx];
    out_data_o.last_in_run = (rest == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (load_i) begin
      pend_q <= bundle_i.present;
    end else if (fire) begin
      pend_q <= rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= bundle_i.res;
    end
  end

endmodule

### sv/gradient_magnitude_stream.sv
`timescale 1ns / 1ps
// Top level of the streaming L1 gradient magnitude over BGR pixels with two line stores.
//
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    gms_pkg::pix_t: blue, green, red
// out      output     out_valid_o / out_stall_i  gms_pkg::res_t: magnitude, row, column, flags
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One pixel is taken per clock while nothing downstream holds it back; a pixel passes the
// input, gradient and output registers before its result leaves. The output register sends
// one result per cycle unless stalled, so on the last row of a frame, where each pixel after
// the first gives two results and the final pixel three, the input is held back to match. Each
// line store is read once per pixel, and the one that takes the current row is also written once per pixel.
// Reset starts a frame in colour mode at 640 by 480; the line stores are not cleared.
// A stall on the output backs up through the three pipeline stages to the input.
module gradient_magnitude_stream (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  gms_pkg::pix_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output gms_pkg::res_t                   out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gms_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [gms_pkg::CfgDataW-1:0]    cfg_data_i
);

  import gms_pkg::*;

  logic                  color_mode_q;
  logic [ColW-1:0]       last_col_q;
  logic [RowW-1:0]       last_row_q;
  logic [ColW-1:0]       last_col_w;
  logic [RowW-1:0]       last_row_w;
  logic [WidthCfgW-1:0]  cfg_w;
  logic [HeightCfgW-1:0] cfg_h;

  logic [ColW-1:0]       col_q;
  logic [ColW-1:0]       col_d;
  logic [RowW-1:0]       row_q;
  logic [RowW-1:0]       row_d;
  logic                  sel_q;
  logic                  sel_d;

  logic                  in_fire;
  logic                  a_ready;
  logic                  a_fire;
  logic                  a_valid_q;
  item_ctl_t             a_ctl_d;
  item_ctl_t             a_ctl_q;
  pix_t                  a_pix_q;
  taps_t                 taps;

  logic                  b_valid;
  logic                  b_ready;
  logic                  b_take;
  bundle_t               bundle;
  logic                  ser_ready;
  logic                  ser_load;

  assign cfg_ready_o = 1'b1;
  assign cfg_w       = cfg_data_i[WidthCfgW-1:0];
  assign cfg_h       = cfg_data_i[HeightCfgW-1:0];

  always_comb begin
    if (int'(cfg_w) < 2) begin
      last_col_w = ColW'(1);
    end else if (int'(cfg_w) > MaxWidth) begin
      last_col_w = ColW'(MaxWidth - 1);
    end else begin
      last_col_w = ColW'(int'(cfg_w) - 1);
    end
    if (int'(cfg_h) < 2) begin
      last_row_w = RowW'(1);
    end else if (int'(cfg_h) > MaxHeight) begin
      last_row_w = RowW'(MaxHeight - 1);
    end else begin
      last_row_w = RowW'(int'(cfg_h) - 1);
    end
  end

  always_comb begin
    col_d = col_q + ColW'(1);
    row_d = row_q;
    sel_d = sel_q;
    if (col_q == last_col_q) begin
      col_d = '0;
      sel_d = ~sel_q;
      row_d = row_q + RowW'(1);
      if (row_q == last_row_q) begin
        row_d = '0;
        sel_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q <= 1'b0;
      last_col_q   <= ColW'(ResetLastCol);
      last_row_q   <= RowW'(ResetLastRow);
      col_q        <= '0;
      row_q        <= '0;
      sel_q        <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegColorMode: begin
          color_mode_q <= cfg_data_i[0];
        end
        RegFrameWidth: begin
          last_col_q <= last_col_w;
          col_q      <= '0;
          row_q      <= '0;
          sel_q      <= 1'b0;
        end
        RegFrameHeight: begin
          last_row_q <= last_row_w;
          col_q      <= '0;
          row_q      <= '0;
          sel_q      <= 1'b0;
        end
        default: begin
        end
      endcase
    end else if (in_fire) begin
      col_q <= col_d;
      row_q <= row_d;
      sel_q <= sel_d;
    end
  end

  assign b_take     = b_valid & ((bundle.present == '0) | ser_ready);
  assign b_ready    = ~b_valid | b_take;
  assign ser_load   = b_valid & (bundle.present != '0) & ser_ready;
  assign a_ready    = ~a_valid_q | b_ready;
  assign a_fire     = a_valid_q & b_ready;
  assign in_stall_o = ~a_ready;
  assign in_fire    = in_valid_i & a_ready;

  assign a_ctl_d = '{row:        row_q,
                     col:        col_q,
                     sel:        sel_q,
                     has_up:     (row_q != '0),
                     second_row: (row_q == RowW'(1)),
                     last_row:   (row_q == last_row_q),
                     col_first:  (col_q == '0),
                     col_second: (col_q == ColW'(1)),
                     col_last:   (col_q == last_col_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= in_fire | (a_valid_q & ~a_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_ctl_q <= a_ctl_d;
      a_pix_q <= in_data_i;
    end
  end

  gms_lbuf u_lbuf (
    .clk_i    (clk_i),
    .wr_en_i  (in_fire),
    .wr_col_i (col_q),
    .wr_sel_i (sel_q),
    .wr_pix_i (in_data_i),
    .adv_i    (a_fire),
    .a_ctl_i  (a_ctl_q),
    .a_pix_i  (a_pix_q),
    .taps_o   (taps)
  );

  gms_grad u_grad (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .color_mode_i (color_mode_q),
    .load_i       (a_fire),
    .take_i       (b_take),
    .a_ctl_i      (a_ctl_q),
    .a_pix_i      (a_pix_q),
    .taps_i       (taps),
    .valid_o      (b_valid),
    .bundle_o     (bundle)
  );

  gms_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (ser_load),
    .bundle_i    (bundle),
    .ready_o     (ser_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### bench/gradient_magnitude_stream_checker.sv
`timescale 1ns / 1ps
// Checker that predicts gradient magnitudes from observed transactions and compares results.
module gradient_magnitude_stream_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  gms_pkg::pix_t                in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  gms_pkg::res_t                out_data_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [gms_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gms_pkg::CfgDataW-1:0] cfg_data_i,
  output int                           fault_count_o,
  output int                           pending_o,
  output int                           checked_o
);
  import gms_pkg::*;

  localparam int unsigned LumaBlue  = 1868;
  localparam int unsigned LumaGreen = 9617;
  localparam int unsigned LumaRed   = 4899;
  localparam int unsigned LumaHalf  = 8192;
  localparam int          LumaShift = 14;
  localparam int          ReportLimit = 10;

  pix_t                  line_a [MaxWidth];
  pix_t                  line_b [MaxWidth];
  logic                  gray_mode;
  logic [WidthCfgW-1:0]  width_reg;
  logic [HeightCfgW-1:0] height_reg;
  int                    col_pos;
  int                    row_pos;
  logic                  swap;
  res_t                  due_magnitudes [$];
  res_t                  wanted;
  int                    faults;
  int                    checked;

  function automatic int bounded(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int luma(pix_t p);
    int unsigned acc;
    acc = LumaBlue * p.blue + LumaGreen * p.green + LumaRed * p.red + LumaHalf;
    return int'(acc >> LumaShift);
  endfunction

  function automatic int span(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int pixel_distance(pix_t p, pix_t q);
    int d;
    int m;
    if (gray_mode) begin
      return span(luma(p), luma(q));
    end
    m = span(p.blue, q.blue);
    d = span(p.green, q.green);
    if (d > m) m = d;
    d = span(p.red, q.red);
    if (d > m) m = d;
    return m;
  endfunction

  // The previous row sits in line_b while swap is low, and the current row in line_a.
  function automatic pix_t upper(int idx);
    return swap ? line_a[idx] : line_b[idx];
  endfunction

  function automatic pix_t current(int idx);
    return swap ? line_b[idx] : line_a[idx];
  endfunction

  function automatic res_t gradient_result(int gx, int gy, int row, int col, logic done);
    res_t r;
    int s;
    s = gx + gy;
    if (s > int'(MagMax)) s = int'(MagMax);
    r.magnitude   = MagW'(s);
    r.out_row     = OutRowW'(row);
    r.out_col     = OutColW'(col);
    r.last_in_run = 1'b0;
    r.frame_done  = done;
    return r;
  endfunction

  task automatic predict_gradients(input pix_t cur);
    res_t batch [MaxRes];
    int n;
    int w;
    int h;
    int c;
    int r;
    int gx;
    int gy;
    n = 0;
    w = bounded(int'(width_reg), 2, MaxWidth);
    h = bounded(int'(height_reg), 2, MaxHeight);
    c = (col_pos >= w) ? 0 : col_pos;
    r = (row_pos >= h) ? 0 : row_pos;
    if (r >= 1) begin
      if (c == 0) gx = 2 * pixel_distance(upper(1), upper(0));
      else if (c == w - 1) gx = 2 * pixel_distance(upper(c), upper(c - 1));
      else gx = pixel_distance(upper(c - 1), upper(c + 1));
      if (r == 1) gy = 2 * pixel_distance(cur, upper(c));
      else gy = pixel_distance(current(c), cur);
      batch[n] = gradient_result(gx, gy, r - 1, c, 1'b0);
      n++;
    end
    if (r == h - 1) begin
      if (c >= 1) begin
        if (c == 1) gx = 2 * pixel_distance(cur, current(0));
        else gx = pixel_distance(current(c - 2), cur);
        gy = 2 * pixel_distance(current(c - 1), upper(c - 1));
        batch[n] = gradient_result(gx, gy, r, c - 1, 1'b0);
        n++;
      end
      if (c == w - 1) begin
        gx = 2 * pixel_distance(cur, current(c - 1));
        gy = 2 * pixel_distance(cur, upper(c));
        batch[n] = gradient_result(gx, gy, r, c, 1'b1);
        n++;
      end
    end
    if (swap) line_b[c] = cur;
    else line_a[c] = cur;
    c++;
    if (c >= w) begin
      c = 0;
      swap = !swap;
      r++;
      if (r >= h) begin
        r = 0;
        swap = 1'b0;
      end
    end
    col_pos = c;
    row_pos = r;
    if (n > 0) batch[n - 1].last_in_run = 1'b1;
    for (int k = 0; k < n; k++) due_magnitudes.insert(due_magnitudes.size(), batch[k]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gray_mode  = 1'b0;
      width_reg  = WidthCfgW'(ResetWidth);
      height_reg = HeightCfgW'(ResetHeight);
      col_pos    = 0;
      row_pos    = 0;
      swap       = 1'b0;
      faults     = 0;
      checked    = 0;
      due_magnitudes.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegColorMode: begin
            gray_mode = cfg_data_i[0];
          end
          RegFrameWidth, RegFrameHeight: begin
            if (cfg_index_i == RegFrameWidth) width_reg = cfg_data_i[WidthCfgW-1:0];
            else height_reg = cfg_data_i[HeightCfgW-1:0];
            col_pos = 0;
            row_pos = 0;
            swap    = 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_gradients(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (due_magnitudes.size() == 0) begin
          faults++;
          if (faults <= ReportLimit) begin
            $display("ERROR: unexpected result transaction mag=%0d row=%0d col=%0d last=%0b done=%0b",
                     out_data_i.magnitude, out_data_i.out_row, out_data_i.out_col,
                     out_data_i.last_in_run, out_data_i.frame_done);
          end
        end else begin
          wanted = due_magnitudes.pop_front();
          if (out_data_i.magnitude !== wanted.magnitude || out_data_i.out_row !== wanted.out_row
              || out_data_i.out_col !== wanted.out_col
              || out_data_i.last_in_run !== wanted.last_in_run
              || out_data_i.frame_done !== wanted.frame_done) begin
            faults++;
            if (faults <= ReportLimit) begin
              $display("ERROR: result %0d expected mag=%0d row=%0d col=%0d last=%0b done=%0b",
                       checked, wanted.magnitude, wanted.out_row, wanted.out_col,
                       wanted.last_in_run, wanted.frame_done);
              $display("       got mag=%0d row=%0d col=%0d last=%0b done=%0b",
                       out_data_i.magnitude, out_data_i.out_row, out_data_i.out_col,
                       out_data_i.last_in_run, out_data_i.frame_done);
            end
          end
        end
      end
    end
    fault_count_o <= faults;
    pending_o     <= due_magnitudes.size();
    checked_o     <= checked;
  end

endmodule

### bench/gradient_magnitude_stream_tb.sv
`timescale 1ns / 1ps
// Testbench top that drives pixel, configuration and stall traffic and reports the verdict.
module gradient_magnitude_stream_tb;
  import gms_pkg::*;

  localparam logic [CfgIdxW-1:0] RegBeyondList = 2'd3;
  localparam int IdleLimit    = 5000;
  localparam int SettleCycles = 8;
  localparam int RandomPixels = 240;
  localparam int PartialRow   = 16;
  localparam int CfgAllOnes   = 8191;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  pix_t                in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  res_t                out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  int   faults;
  int   pending;
  int   checked;
  int   idle_cycles   = 0;
  int   stall_style   = 0;
  int   stall_left    = 0;
  int   stall_tick    = 0;
  int   burst_left    = 0;
  bit   steady_sender = 1'b0;
  int   pixels_sent   = 0;
  int   settings_used = 0;
  pix_t scene         = '0;

  gradient_magnitude_stream dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  gradient_magnitude_stream_checker gradient_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fault_count_o (faults),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(50, 400);
    end
    stall_left--;
    stall_tick++;
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= ((stall_tick % 5) < 3);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("ERROR: no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int clamp_size(int v, int hi);
    return (v < 2) ? 2 : ((v > hi) ? hi : v);
  endfunction

  function automatic pix_t bgr(int b, int g, int r);
    return {8'(b), 8'(g), 8'(r)};
  endfunction

  function automatic logic [7:0] nudge(logic [7:0] v);
    int x;
    x = int'(v) + int'($urandom_range(0, 16)) - 8;
    return (x < 0) ? 8'd0 : ((x > 255) ? 8'd255 : 8'(x));
  endfunction

  function automatic logic [7:0] extreme_level();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd127;
      3: return 8'd128;
      4: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // About half the content is smooth so that many magnitudes stay below saturation; the rest is random or extreme.
  function automatic pix_t next_pixel();
    int style;
    style = $urandom_range(0, 9);
    if (style < 5) scene = {nudge(scene.blue), nudge(scene.green), nudge(scene.red)};
    else if (style < 8) scene = 24'($urandom);
    else scene = {extreme_level(), extreme_level(), extreme_level()};
    return scene;
  endfunction

  task automatic send_pixel(input pix_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady_sender ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgDataW'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_geometry(input int mode_val, input int width_val, input int height_val);
    write_reg(RegColorMode, mode_val);
    write_reg(RegFrameWidth, width_val);
    write_reg(RegFrameHeight, height_val);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic set_mode(input int mode_val);
    write_reg(RegColorMode, mode_val);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int mode;
    int w_val;
    int h_val;
    int total;
    int stop_at;
    int flip_at;
    int random_pixels;
    random_pixels = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A few pixels of the first row at the reset geometry give no results.
    for (int k = 0; k < 3; k++) send_pixel(next_pixel());
    wait_for_results();

    // Sizes below the minimum are raised to a two by two frame.
    set_geometry(0, 0, 1);
    send_pixel(bgr(0, 0, 0));
    send_pixel(bgr(255, 255, 255));
    send_pixel(bgr(255, 0, 0));
    send_pixel(bgr(0, 255, 255));
    wait_for_results();

    set_geometry(CfgAllOnes, 3, 3);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) send_pixel(bgr(10 + 30 * c, 200 - 40 * r, 60 + 20 * (r + c)));
    end
    wait_for_results();

    write_reg(RegBeyondList, CfgAllOnes);
    set_geometry(0, 2, 2);
    send_pixel(bgr(255, 0, 255));
    send_pixel(bgr(0, 255, 0));
    send_pixel(bgr(0, 255, 0));
    send_pixel(bgr(255, 0, 255));
    wait_for_results();

    // Very tall frame, paused mid-way until all results are out, then abandoned.
    set_geometry(0, 2, CfgAllOnes);
    for (int k = 0; k < 6; k++) send_pixel(next_pixel());
    wait_for_results();
    for (int k = 0; k < 6; k++) send_pixel(next_pixel());
    wait_for_results();

    set_geometry(1, MaxWidth, MaxHeight);
    for (int k = 0; k < 5; k++) send_pixel(next_pixel());
    wait_for_results();

    // An oversized width is clamped to the line store size; only part of a row is sent.
    set_geometry($urandom_range(0, 1), 2047, 2);
    for (int k = 0; k < PartialRow; k++) send_pixel(next_pixel());
    wait_for_results();

    while (random_pixels < RandomPixels) begin
      mode  = $urandom_range(0, 1);
      w_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 10);
      h_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 5);
      steady_sender = ($urandom_range(0, 3) == 0);
      set_geometry(mode, w_val, h_val);
      total = clamp_size(w_val, MaxWidth) * clamp_size(h_val, MaxHeight)
            * $urandom_range(1, 2);
      stop_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, total - 1) : total;
      flip_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, total - 1) : -1;
      for (int k = 0; k < stop_at; k++) begin
        if (k == flip_at) begin
          wait_for_results();
          mode = 1 - mode;
          set_mode(mode);
        end
        send_pixel(next_pixel());
        random_pixels++;
      end
      wait_for_results();
    end

    $display("Summary: %0d pixels under %0d frame settings, %0d magnitudes compared.",
             pixels_sent, settings_used, checked);
    $display("Summary: colour and grey distance, small frames, clamped sizes, restarts.");
    if (faults == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### gradient_magnitude_stream.f
sv/gms_pkg.sv
sv/gms_ram.sv
sv/gms_lbuf.sv
sv/gms_grad.sv
sv/gms_out.sv
sv/gradient_magnitude_stream.sv
bench/gradient_magnitude_stream_checker.sv
bench/gradient_magnitude_stream_tb.sv
